// ===== rtl/assert_macros.svh =====
// Assertion macros used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

// ===== rtl/eds_pkg.sv =====
package eds_pkg;

  // Request function codes.
  localparam logic [2:0] FUNC_ADD     = 3'd0;
  localparam logic [2:0] FUNC_SET     = 3'd1;
  localparam logic [2:0] FUNC_DIR     = 3'd2;
  localparam logic [2:0] FUNC_DIR_CLR = 3'd3;
  localparam logic [2:0] FUNC_STOP    = 3'd4;
  localparam logic [2:0] FUNC_CLR_ALL = 3'd5;

  // Motor direction codes.
  localparam logic [1:0] DIR_STOP = 2'd0;
  localparam logic [1:0] DIR_UP   = 2'd1;
  localparam logic [1:0] DIR_DOWN = 2'd2;

  // Button kinds, which are also the bit positions in an order entry.
  localparam logic [1:0] BTN_UP   = 2'd0;
  localparam logic [1:0] BTN_DOWN = 2'd1;
  localparam logic [1:0] BTN_CAB  = 2'd2;

  // Order entry masks.
  localparam logic [2:0] MASK_UP   = 3'b001;
  localparam logic [2:0] MASK_DOWN = 3'b010;
  localparam logic [2:0] MASK_CAB  = 3'b100;

  // Fixed result field widths and the most floors packed into pending_orders.
  localparam int FLOOR_NOW_W = 2;
  localparam int PENDING_W   = 12;
  localparam int PACK_MAX    = 4;

  // Controller states.
  typedef enum logic [2:0] {
    S_IDLE   = 3'b001,
    S_EXEC   = 3'b010,
    S_FINISH = 3'b100
  } eds_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;
    logic exec;
    logic finish;
  } eds_cmd_t;

endpackage

// ===== rtl/elevator_direction_scheduler.sv =====
// A request accepted on an edge with start high and busy low gives its result
// with done high after the execute step and then the finish step.
// A new request can be taken in the finish step; busy is high only in the execute step.
// Reset (rst, synchronous, active high) clears all orders, sets the floor to 0 and the
// direction to stop. The receiver cannot stall: each result is shown for one cycle.
`include "assert_macros.svh"

module elevator_direction_scheduler import eds_pkg::*; #(
  parameter int FLOOR_COUNT = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   start,
  output logic                   busy,
  input  logic [2:0]             func,
  input  logic                   at_floor,
  input  logic [1:0]             floor_index,
  input  logic [1:0]             button_kind,
  output logic                   done,
  output logic [1:0]             motor_direction,
  output logic                   should_stop,
  output logic [FLOOR_NOW_W-1:0] floor_now,
  output logic [PENDING_W-1:0]   pending_orders
);

  eds_cmd_t cmd;

  // Sequencing of each request.
  eds_controller u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .cmd   (cmd)
  );

  // Order table, floor, direction and result registers.
  eds_datapath #(
    .FLOOR_COUNT (FLOOR_COUNT)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .cmd             (cmd),
    .func            (func),
    .at_floor        (at_floor),
    .floor_index     (floor_index),
    .button_kind     (button_kind),
    .motor_direction (motor_direction),
    .should_stop     (should_stop),
    .floor_now       (floor_now),
    .pending_orders  (pending_orders),
    .done            (done)
  );

  // An accepted request always enters the execute step.
  `ASSERT_NEXT(a_accept_exec, clk, rst, cmd.load, cmd.exec && busy)
  // The execute step always hands over to the finish step.
  `ASSERT_NEXT(a_exec_finish, clk, rst, cmd.exec, cmd.finish && !busy)
  // A result strobe follows a finish step and carries a valid direction code.
  `ASSERT_IMPLIES(a_done_dir, clk, rst, done, motor_direction <= DIR_DOWN)

endmodule

// ===== rtl/eds_controller.sv =====
module eds_controller import eds_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  output logic     busy,
  output eds_cmd_t cmd
);

  eds_state_t state, state_next;

  // Only the execute step blocks a new request.
  assign busy       = (state == S_EXEC);
  assign cmd.load   = start && !busy;
  assign cmd.exec   = (state == S_EXEC);
  assign cmd.finish = (state == S_FINISH);

  // Next-state logic.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   state_next = start ? S_EXEC : S_IDLE;
      S_EXEC:   state_next = S_FINISH;
      S_FINISH: state_next = start ? S_EXEC : S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // State register.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/eds_datapath.sv =====
module eds_datapath import eds_pkg::*; #(
  parameter int FLOOR_COUNT = 4
) (
  input  logic                   clk,
  input  logic                   rst,
  input  eds_cmd_t               cmd,
  input  logic [2:0]             func,
  input  logic                   at_floor,
  input  logic [1:0]             floor_index,
  input  logic [1:0]             button_kind,
  output logic [1:0]             motor_direction,
  output logic                   should_stop,
  output logic [FLOOR_NOW_W-1:0] floor_now,
  output logic [PENDING_W-1:0]   pending_orders,
  output logic                   done
);

  localparam int FW = (FLOOR_COUNT > 2) ? $clog2(FLOOR_COUNT) : 1;
  localparam int PACK_FLOORS = (FLOOR_COUNT < PACK_MAX) ? FLOOR_COUNT : PACK_MAX;
  localparam logic [FW-1:0] TOP_FLOOR = FW'(FLOOR_COUNT - 1);

  // Latched request.
  logic [2:0] func_q;
  logic       at_floor_q;
  logic [1:0] fidx_q;
  logic [1:0] kind_q;

  // Scheduler state.
  logic [2:0]    orders [FLOOR_COUNT];
  logic [FW-1:0] floor_q;
  logic [1:0]    dir_q;

  // Results of the execute step.
  logic [1:0] dir_res;
  logic       stop_res;

  logic          nb, na, nh;
  logic [2:0]    here;
  logic [1:0]    dec_dir;
  logic [FW-1:0] dec_floor;
  logic [1:0]    dec_ret;
  logic          stop_calc;
  logic [2:0]    clr_mask;
  logic [2:0]    fin_orders [FLOOR_COUNT];
  logic [PENDING_W-1:0] pack_next;

  // Order presence below, above and at the current floor.
  always_comb begin
    nb = 1'b1;
    na = 1'b1;
    for (int i = 0; i < FLOOR_COUNT; i++) begin
      if (FW'(i) < floor_q && (|orders[i])) nb = 1'b0;
      if (FW'(i) > floor_q && (|orders[i])) na = 1'b0;
    end
    here = orders[floor_q];
    nh   = (here == 3'b000);
  end

  // Direction decision, including the floor nudge on a reversal between floors.
  always_comb begin
    dec_dir   = dir_q;
    dec_floor = floor_q;
    dec_ret   = DIR_STOP;
    if (at_floor_q) begin
      if (nb && na && nh) begin
        dec_dir = DIR_STOP;
      end else if (dir_q == DIR_UP) begin
        dec_dir = na ? DIR_DOWN : DIR_UP;
      end else if (dir_q == DIR_DOWN) begin
        dec_dir = nb ? DIR_UP : DIR_DOWN;
      end else if (!nh) begin
        if (!nb) dec_dir = DIR_DOWN;
        else if (!na) dec_dir = DIR_UP;
        else dec_dir = DIR_STOP;
      end else begin
        dec_dir = nb ? DIR_UP : DIR_DOWN;
      end
      dec_ret = dec_dir;
    end else if (dir_q == DIR_UP) begin
      if (na) begin
        if (floor_q < TOP_FLOOR) dec_floor = floor_q + FW'(1);
        dec_dir = DIR_DOWN;
      end
      dec_ret = dec_dir;
    end else if (dir_q == DIR_DOWN) begin
      if (nb) begin
        if (floor_q != '0) dec_floor = floor_q - FW'(1);
        dec_dir = DIR_UP;
      end
      dec_ret = dec_dir;
    end
  end

  // Stop check at the current floor.
  always_comb begin
    if (dir_q == DIR_UP) begin
      stop_calc = (|(here & (MASK_UP | MASK_CAB))) || na;
    end else if (dir_q == DIR_DOWN) begin
      stop_calc = (|(here & (MASK_DOWN | MASK_CAB))) || nb;
    end else begin
      stop_calc = 1'b1;
    end
  end

  // Orders served at the current floor, taken after the decision has settled.
  always_comb begin
    if (dir_res == DIR_UP) begin
      clr_mask = MASK_UP | MASK_CAB | (na ? MASK_DOWN : 3'b000);
    end else if (dir_res == DIR_DOWN) begin
      clr_mask = MASK_DOWN | MASK_CAB | (nb ? MASK_UP : 3'b000);
    end else if (!nb) begin
      clr_mask = MASK_DOWN | MASK_CAB;
    end else if (!na) begin
      clr_mask = MASK_UP | MASK_CAB;
    end else begin
      clr_mask = MASK_UP | MASK_DOWN | MASK_CAB;
    end
  end

  // Order table as it stands after the finish step, and its packed view.
  always_comb begin
    for (int i = 0; i < FLOOR_COUNT; i++) begin
      fin_orders[i] = orders[i];
      if (func_q == FUNC_DIR_CLR && FW'(i) == floor_q) begin
        fin_orders[i] = orders[i] & ~clr_mask;
      end
    end
    pack_next = '0;
    for (int i = 0; i < PACK_FLOORS; i++) begin
      pack_next[3*i +: 3] = fin_orders[i];
    end
  end

  // Scheduler state and result strobe.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < FLOOR_COUNT; i++) orders[i] <= 3'b000;
      floor_q <= '0;
      dir_q   <= DIR_STOP;
      done    <= 1'b0;
    end else begin
      done <= cmd.finish;
      if (cmd.exec) begin
        case (func_q)
          FUNC_ADD: begin
            if (int'(fidx_q) < FLOOR_COUNT && kind_q <= BTN_CAB) begin
              orders[FW'(fidx_q)][kind_q] <= 1'b1;
            end
          end
          FUNC_SET: begin
            floor_q <= (int'(fidx_q) < FLOOR_COUNT) ? FW'(fidx_q) : TOP_FLOOR;
          end
          FUNC_DIR, FUNC_DIR_CLR: begin
            dir_q   <= dec_dir;
            floor_q <= dec_floor;
          end
          FUNC_CLR_ALL: begin
            for (int i = 0; i < FLOOR_COUNT; i++) orders[i] <= 3'b000;
          end
          default: begin
          end
        endcase
      end
      if (cmd.finish) begin
        for (int i = 0; i < FLOOR_COUNT; i++) orders[i] <= fin_orders[i];
      end
    end
  end

  // Request capture, step results and output registers.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      func_q     <= func;
      at_floor_q <= at_floor;
      fidx_q     <= floor_index;
      kind_q     <= button_kind;
    end
    if (cmd.exec) begin
      dir_res  <= (func_q == FUNC_DIR || func_q == FUNC_DIR_CLR) ? dec_ret : DIR_STOP;
      stop_res <= (func_q == FUNC_STOP) ? stop_calc : 1'b0;
    end
    if (cmd.finish) begin
      motor_direction <= dir_res;
      should_stop     <= stop_res;
      floor_now       <= FLOOR_NOW_W'(floor_q);
      pending_orders  <= pack_next;
    end
  end

endmodule
